// ----- hdl/chunk_location_ttl_cache_core_defines.svh -----
// Assertion macros shared by the cache core.
`ifndef CHUNK_LOCATION_TTL_CACHE_CORE_DEFINES_SVH
`define CHUNK_LOCATION_TTL_CACHE_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CLC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define CLC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CLC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define CLC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- hdl/clc_pkg.sv -----
package clc_pkg;

    localparam int DEF_SET_BITS       = 8;
    localparam int DEF_WAYS           = 4;
    localparam int DEF_LOCS_PER_ENTRY = 4;
    localparam int DEF_LOC_WIDTH      = 64;

    localparam logic [63:0] HASH_MULT = 64'h61C8864680B583EB;
    localparam logic [31:0] TTL_RESET = 32'd250;
    localparam int          RESULT_LIMIT = 4;

    // Register index of the TTL register.
    localparam logic REG_TTL = 1'b0;

    typedef enum logic [1:0] {
        MODE_STORE  = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_PURGE  = 2'd2,
        MODE_TICK   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_RD,
        ST_CHK,
        ST_WR,
        ST_LRD,
        ST_LOUT,
        ST_MISS,
        ST_PRD,
        ST_PCHK
    } state_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] inode;
        logic [31:0] blk_index;
        logic [63:0] blk_id;
        logic [31:0] blk_version;
        logic [1:0]  loc_index;
        logic [63:0] loc_value;
        logic        loc_last;
        logic [2:0]  max_locs;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] chunk_id_out;
        logic [31:0] chunk_version_out;
        logic [63:0] loc_value_out;
        logic [1:0]  loc_index_out;
        logic        last;
    } out_item_t;

endpackage

// ----- hdl/chunk_location_ttl_cache_core.sv -----
// Set-associative cache of chunk locations with expiry, keyed by inode and chunk index.
// Items arrive on the s_ channel (valid/ready); lookup results leave on the m_ channel,
// one transfer per location with last on the final one. A miss is a single transfer
// with hit low and last high. The TTL register sits at byte address 0 of the APB port.
// Per item: a tick only advances time. A store item that continues an open store
// goes straight to its write. The first item of a store and a lookup with a nonzero
// limit pass through the shared hash multiplier, then read the set way by way, one
// memory read per way inspected. A lookup hit then streams its locations out one by
// one. A purge walks every entry through the single entry read port.
// After reset the valid store is cleared one entry a cycle, during which s_ready
// stays low; APB writes are taken throughout.
// Results sit in an output register, so a new item is accepted while a result waits;
// a lookup that needs the output register simply holds until m_ready frees it.
module chunk_location_ttl_cache_core #(
    parameter int SET_BITS       = clc_pkg::DEF_SET_BITS,
    parameter int WAYS           = clc_pkg::DEF_WAYS,
    parameter int LOCS_PER_ENTRY = clc_pkg::DEF_LOCS_PER_ENTRY,
    parameter int LOC_WIDTH      = clc_pkg::DEF_LOC_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  clc_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output clc_pkg::out_item_t   m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
`include "chunk_location_ttl_cache_core_defines.svh"

    localparam int NSETS  = 1 << SET_BITS;
    localparam int NENT   = NSETS * WAYS;
    localparam int ENT_W  = $clog2(NENT);
    localparam int NLOC   = NENT * LOCS_PER_ENTRY;
    localparam int LOC_AW = $clog2(NLOC);
    localparam int WAY_CW = $clog2(WAYS + 1);
    localparam int CNT_W  = $clog2(LOCS_PER_ENTRY + 1);

    // Entry storage. Only the valid bits have a defined reset, applied by a clearing pass.
    logic                 valid_mem [NENT];
    logic [63:0]          key_mem   [NENT];
    logic [63:0]          id_mem    [NENT];
    logic [31:0]          ver_mem   [NENT];
    logic [CNT_W-1:0]     cnt_mem   [NENT];
    logic [31:0]          exp_mem   [NENT];
    logic [LOC_WIDTH-1:0] loc_mem   [NLOC];

    clc_pkg::state_t   state_reg, state_next;
    clc_pkg::in_item_t item_reg, item_next;
    clc_pkg::out_item_t out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    logic [31:0]       ttl_reg;
    logic [31:0]       now_reg, now_next;
    logic              store_open_reg, store_open_next;
    logic              store_drop_reg, store_drop_next;
    logic [ENT_W-1:0]  fill_ent_reg, fill_ent_next;
    logic [31:0]       fill_inode_reg, fill_inode_next;
    logic [SET_BITS-1:0] set_reg, set_next;
    logic [WAY_CW-1:0] way_reg, way_next;
    logic [ENT_W:0]    ent_cnt_reg, ent_cnt_next;
    logic              have_inv_reg, have_inv_next;
    logic [WAY_CW-1:0] inv_way_reg, inv_way_next;
    logic              have_exp_reg, have_exp_next;
    logic [WAY_CW-1:0] exp_way_reg, exp_way_next;
    logic [ENT_W-1:0]  hit_ent_reg, hit_ent_next;
    logic [63:0]       hit_id_reg, hit_id_next;
    logic [31:0]       hit_ver_reg, hit_ver_next;
    logic [2:0]        n_reg, n_next;
    logic [2:0]        k_reg, k_next;

    // Registered read data of the entry and location ports.
    logic                 rd_valid_q;
    logic [63:0]          rd_key_q, rd_id_q;
    logic [31:0]          rd_ver_q, rd_exp_q;
    logic [CNT_W-1:0]     rd_cnt_q;
    logic [LOC_WIDTH-1:0] loc_q;

    // Write ports.
    logic                 vwr_en, vwr_data;
    logic [ENT_W-1:0]     vwr_addr;
    logic                 hwr_en;
    logic [ENT_W-1:0]     hwr_addr;
    logic                 cwr_en;
    logic [CNT_W-1:0]     cwr_cnt;
    logic                 lwr_en;
    logic [LOC_AW-1:0]    lwr_addr;

    logic [ENT_W-1:0]     rd_ent;
    logic [LOC_AW-1:0]    loc_rd_addr;
    logic [ENT_W-1:0]     scan_ent;

    logic                 hash_start;
    logic [63:0]          hash_key;
    logic                 hash_done;
    logic [SET_BITS-1:0]  hash_set;

    logic [63:0]          item_key;
    logic [31:0]          age, age_m1;
    logic                 expired, match, last_way, out_free;
    logic [4:0]           slot_ext, slot_plus, cnt_ext, n_a;
    logic                 slot_ok;
    logic                 pick_ok;
    logic [WAY_CW-1:0]    pick_way;
    logic                 inv_any, exp_any;
    logic [WAY_CW-1:0]    inv_w, exp_w;
    logic                 apb_wr;

    clc_hash #(
        .SET_BITS (SET_BITS)
    ) u_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (hash_start),
        .key       (hash_key),
        .done      (hash_done),
        .set_index (hash_set)
    );

    assign item_key  = {item_reg.inode, item_reg.blk_index};
    assign hash_key  = {s_data.inode, s_data.blk_index};
    assign scan_ent  = ENT_W'(ENT_W'(set_reg) * ENT_W'(WAYS) + ENT_W'(way_reg));
    assign age       = now_reg - rd_exp_q;
    assign age_m1    = age - 32'd1;
    // Expired when now lies past the expiry by one tick up to half the range of the
    // wrapping counter, the half-range distance itself included.
    assign expired   = !age_m1[31] && (age != 32'd0);
    assign match     = rd_valid_q && (rd_key_q == item_key);
    assign last_way  = (way_reg == WAY_CW'(WAYS - 1));
    assign out_free  = !m_valid_reg || m_ready;
    assign slot_ext  = 5'(item_reg.loc_index);
    assign slot_plus = slot_ext + 5'd1;
    assign slot_ok   = slot_ext < 5'(LOCS_PER_ENTRY);
    assign cwr_cnt   = (slot_plus > 5'(LOCS_PER_ENTRY)) ? CNT_W'(LOCS_PER_ENTRY)
                                                        : CNT_W'(slot_plus);
    assign cnt_ext   = 5'(rd_cnt_q);
    assign n_a       = (5'(item_reg.max_locs) < cnt_ext) ? 5'(item_reg.max_locs) : cnt_ext;

    assign rd_ent      = (state_reg == clc_pkg::ST_PRD) ? ent_cnt_reg[ENT_W-1:0] : scan_ent;
    assign loc_rd_addr = LOC_AW'(LOC_AW'(hit_ent_reg) * LOC_AW'(LOCS_PER_ENTRY)
                                 + LOC_AW'(k_reg));
    assign lwr_addr    = LOC_AW'(LOC_AW'(fill_ent_reg) * LOC_AW'(LOCS_PER_ENTRY)
                                 + LOC_AW'(item_reg.loc_index));

    // Way choice for the first item of a store: a valid key match, else the lowest free way,
    // else the lowest expired way. The running picks include the way now being read.
    always_comb begin
        inv_any = have_inv_reg || !rd_valid_q;
        inv_w   = have_inv_reg ? inv_way_reg : way_reg;
        exp_any = have_exp_reg || (rd_valid_q && expired);
        exp_w   = have_exp_reg ? exp_way_reg : way_reg;
        if (match) begin
            pick_ok  = 1'b1;
            pick_way = way_reg;
        end else if (inv_any) begin
            pick_ok  = 1'b1;
            pick_way = inv_w;
        end else begin
            pick_ok  = exp_any;
            pick_way = exp_w;
        end
    end

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        now_next        = now_reg;
        store_open_next = store_open_reg;
        store_drop_next = store_drop_reg;
        fill_ent_next   = fill_ent_reg;
        fill_inode_next = fill_inode_reg;
        set_next        = set_reg;
        way_next        = way_reg;
        ent_cnt_next    = ent_cnt_reg;
        have_inv_next   = have_inv_reg;
        inv_way_next    = inv_way_reg;
        have_exp_next   = have_exp_reg;
        exp_way_next    = exp_way_reg;
        hit_ent_next    = hit_ent_reg;
        hit_id_next     = hit_id_reg;
        hit_ver_next    = hit_ver_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        s_ready         = 1'b0;
        hash_start      = 1'b0;
        vwr_en          = 1'b0;
        vwr_data        = 1'b0;
        vwr_addr        = scan_ent;
        hwr_en          = 1'b0;
        hwr_addr        = scan_ent;
        cwr_en          = 1'b0;
        lwr_en          = 1'b0;

        unique case (state_reg)
            clc_pkg::ST_CLEAR: begin
                vwr_en       = 1'b1;
                vwr_addr     = ent_cnt_reg[ENT_W-1:0];
                ent_cnt_next = ent_cnt_reg + (ENT_W+1)'(1);
                if (ent_cnt_reg == (ENT_W+1)'(NENT - 1)) begin
                    state_next = clc_pkg::ST_IDLE;
                end
            end
            clc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next = s_data;
                    unique case (s_data.mode)
                        clc_pkg::MODE_STORE: begin
                            if (store_open_reg) begin
                                state_next = clc_pkg::ST_WR;
                            end else begin
                                hash_start = 1'b1;
                                state_next = clc_pkg::ST_HASH;
                            end
                        end
                        clc_pkg::MODE_LOOKUP: begin
                            if (s_data.max_locs == 3'd0) begin
                                state_next = clc_pkg::ST_MISS;
                            end else begin
                                hash_start = 1'b1;
                                state_next = clc_pkg::ST_HASH;
                            end
                        end
                        clc_pkg::MODE_PURGE: begin
                            ent_cnt_next = '0;
                            state_next   = clc_pkg::ST_PRD;
                        end
                        default: begin
                            now_next = now_reg + 32'd1;
                        end
                    endcase
                end
            end
            clc_pkg::ST_HASH: begin
                if (hash_done) begin
                    set_next      = hash_set;
                    way_next      = '0;
                    have_inv_next = 1'b0;
                    have_exp_next = 1'b0;
                    state_next    = clc_pkg::ST_RD;
                end
            end
            clc_pkg::ST_RD: begin
                state_next = clc_pkg::ST_CHK;
            end
            clc_pkg::ST_CHK: begin
                if (item_reg.mode == clc_pkg::MODE_LOOKUP) begin
                    if (match) begin
                        if (expired) begin
                            vwr_en     = 1'b1;
                            state_next = clc_pkg::ST_MISS;
                        end else begin
                            hit_ent_next = scan_ent;
                            hit_id_next  = rd_id_q;
                            hit_ver_next = rd_ver_q;
                            n_next       = (n_a > 5'(clc_pkg::RESULT_LIMIT))
                                           ? 3'(clc_pkg::RESULT_LIMIT) : 3'(n_a);
                            k_next       = 3'd0;
                            state_next   = (n_a == 5'd0) ? clc_pkg::ST_MISS
                                                         : clc_pkg::ST_LRD;
                        end
                    end else if (last_way) begin
                        state_next = clc_pkg::ST_MISS;
                    end else begin
                        way_next   = way_reg + WAY_CW'(1);
                        state_next = clc_pkg::ST_RD;
                    end
                end else begin
                    if (match || last_way) begin
                        store_open_next = 1'b1;
                        store_drop_next = !pick_ok;
                        state_next      = clc_pkg::ST_WR;
                        if (pick_ok) begin
                            fill_ent_next   = ENT_W'(ENT_W'(set_reg) * ENT_W'(WAYS)
                                                     + ENT_W'(pick_way));
                            fill_inode_next = item_reg.inode;
                            vwr_en          = 1'b1;
                            vwr_addr        = fill_ent_next;
                            hwr_en          = 1'b1;
                            hwr_addr        = fill_ent_next;
                        end
                    end else begin
                        have_inv_next = inv_any;
                        inv_way_next  = inv_w;
                        have_exp_next = exp_any;
                        exp_way_next  = exp_w;
                        way_next      = way_reg + WAY_CW'(1);
                        state_next    = clc_pkg::ST_RD;
                    end
                end
            end
            clc_pkg::ST_WR: begin
                if (!store_drop_reg) begin
                    lwr_en = slot_ok;
                    if (item_reg.loc_last) begin
                        cwr_en   = 1'b1;
                        vwr_en   = 1'b1;
                        vwr_data = 1'b1;
                        vwr_addr = fill_ent_reg;
                    end
                end
                if (item_reg.loc_last) begin
                    store_open_next = 1'b0;
                    store_drop_next = 1'b0;
                end
                state_next = clc_pkg::ST_IDLE;
            end
            clc_pkg::ST_LRD: begin
                state_next = clc_pkg::ST_LOUT;
            end
            clc_pkg::ST_LOUT: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    out_next.hit               = 1'b1;
                    out_next.chunk_id_out      = hit_id_reg;
                    out_next.chunk_version_out = hit_ver_reg;
                    out_next.loc_value_out     = 64'(loc_q);
                    out_next.loc_index_out     = k_reg[1:0];
                    out_next.last              = (k_reg + 3'd1 == n_reg);
                    k_next                     = k_reg + 3'd1;
                    state_next = (k_reg + 3'd1 == n_reg) ? clc_pkg::ST_IDLE
                                                         : clc_pkg::ST_LRD;
                end
            end
            clc_pkg::ST_MISS: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_next      = '0;
                    out_next.last = 1'b1;
                    state_next    = clc_pkg::ST_IDLE;
                end
            end
            clc_pkg::ST_PRD: begin
                state_next = clc_pkg::ST_PCHK;
            end
            clc_pkg::ST_PCHK: begin
                vwr_addr = ent_cnt_reg[ENT_W-1:0];
                vwr_en   = rd_valid_q && (rd_key_q[63:32] == item_reg.inode);
                if (ent_cnt_reg == (ENT_W+1)'(NENT - 1)) begin
                    if (store_open_reg && !store_drop_reg
                        && (fill_inode_reg == item_reg.inode)) begin
                        store_drop_next = 1'b1;
                    end
                    state_next = clc_pkg::ST_IDLE;
                end else begin
                    ent_cnt_next = ent_cnt_reg + (ENT_W+1)'(1);
                    state_next   = clc_pkg::ST_PRD;
                end
            end
            default: begin
                state_next = clc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= clc_pkg::ST_CLEAR;
            ent_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
            now_reg        <= 32'd0;
            store_open_reg <= 1'b0;
            store_drop_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ent_cnt_reg    <= ent_cnt_next;
            m_valid_reg    <= m_valid_next;
            now_reg        <= now_next;
            store_open_reg <= store_open_next;
            store_drop_reg <= store_drop_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg       <= item_next;
        out_reg        <= out_next;
        fill_ent_reg   <= fill_ent_next;
        fill_inode_reg <= fill_inode_next;
        set_reg        <= set_next;
        way_reg        <= way_next;
        have_inv_reg   <= have_inv_next;
        inv_way_reg    <= inv_way_next;
        have_exp_reg   <= have_exp_next;
        exp_way_reg    <= exp_way_next;
        hit_ent_reg    <= hit_ent_next;
        hit_id_reg     <= hit_id_next;
        hit_ver_reg    <= hit_ver_next;
        n_reg          <= n_next;
        k_reg          <= k_next;
    end

    // Entry and location memories: one write and one registered read per cycle each.
    always_ff @(posedge aclk) begin
        if (vwr_en) begin
            valid_mem[vwr_addr] <= vwr_data;
        end
        if (hwr_en) begin
            key_mem[hwr_addr] <= item_key;
            id_mem[hwr_addr]  <= item_reg.blk_id;
            ver_mem[hwr_addr] <= item_reg.blk_version;
        end
        if (cwr_en) begin
            cnt_mem[fill_ent_reg] <= cwr_cnt;
            exp_mem[fill_ent_reg] <= now_reg + ttl_reg;
        end
        rd_valid_q <= valid_mem[rd_ent];
        rd_key_q   <= key_mem[rd_ent];
        rd_id_q    <= id_mem[rd_ent];
        rd_ver_q   <= ver_mem[rd_ent];
        rd_cnt_q   <= cnt_mem[rd_ent];
        rd_exp_q   <= exp_mem[rd_ent];
    end

    always_ff @(posedge aclk) begin
        if (lwr_en) begin
            loc_mem[lwr_addr] <= item_reg.loc_value[LOC_WIDTH-1:0];
        end
        loc_q <= loc_mem[loc_rd_addr];
    end

    // APB register port: zero wait states, TTL register at byte address 0.
    assign apb_wr = psel && penable && pwrite;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ttl_reg <= clc_pkg::TTL_RESET;
        end else if (apb_wr && (paddr[2] == clc_pkg::REG_TTL)) begin
            ttl_reg <= pwdata;
        end
    end
    assign prdata = (paddr[2] == clc_pkg::REG_TTL) ? ttl_reg : 32'd0;
    assign pready = 1'b1;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `CLC_ASSERT_IMP(a_miss_is_last, aclk, aresetn, m_valid_reg && !out_reg.hit, out_reg.last, "miss result without last")
    `CLC_ASSERT_IMP(a_drop_needs_open, aclk, aresetn, store_drop_reg, store_open_reg, "dropped store not open")
    `CLC_ASSERT_IMP(a_emit_in_range, aclk, aresetn, state_reg == clc_pkg::ST_LOUT, k_reg < n_reg, "location index past count")
    `CLC_ASSERT_NXT(a_tick_advances, aclk, aresetn, s_valid && s_ready && (s_data.mode == clc_pkg::MODE_TICK), now_reg == $past(now_reg) + 32'd1, "tick did not advance time")

endmodule

// ----- hdl/clc_hash.sv -----
// Set index from the top bits of key times a fixed odd constant, modulo 2^64.
// One 32x32 multiplier is used three times; the high-by-high product drops out.
module clc_hash #(
    parameter int SET_BITS = clc_pkg::DEF_SET_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [63:0]         key,
    output logic                done,
    output logic [SET_BITS-1:0] set_index
);

    logic [63:0] key_reg;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] prod_reg;
    logic [1:0]  step_reg, step_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [31:0] op_a, op_b;

    always_comb begin
        op_a      = key_reg[31:0];
        op_b      = clc_pkg::HASH_MULT[31:0];
        acc_next  = acc_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        case (step_reg)
            2'd1: begin
                op_a     = key_reg[63:32];
                acc_next = prod_reg;
            end
            2'd2: begin
                op_b     = clc_pkg::HASH_MULT[63:32];
                acc_next = acc_reg + {prod_reg[31:0], 32'd0};
            end
            default: begin
                acc_next = acc_reg + {prod_reg[31:0], 32'd0};
            end
        endcase
        if (run_reg) begin
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd3) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else if (start) begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg <= key;
        end else if (run_reg) begin
            prod_reg <= op_a * op_b;
            if (step_reg != 2'd0) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign done      = done_reg;
    assign set_index = acc_reg[63 -: SET_BITS];

endmodule

// ----- verif/testbench.sv -----
module testbench;

    localparam int NWAYS        = 4;
    localparam int NENT         = 1024;
    localparam int NLOC         = 4;
    // A purge walks all 1024 entries; this covers any silent work.
    localparam int DRAIN_CYCLES = 2400;

    typedef struct packed {
        clc_pkg::in_item_t          d;
        logic [2:0]                 nres;
        clc_pkg::out_item_t [3:0]   res;
        logic                       pause;
        logic                       wr;
        logic [31:0]                val;
    } job_t;

    typedef enum {DRV_RUN, DRV_DRAIN, DRV_SETUP, DRV_ACCESS} drv_state_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               m_ready = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    clc_pkg::in_item_t  s_data = '0;
    wire                s_ready;
    wire                m_valid;
    wire                pready;
    wire [31:0]         prdata;
    clc_pkg::out_item_t m_data;

    chunk_location_ttl_cache_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // The testbench's own copy of the cache contents, time and TTL.
    logic        cache_valid   [NENT];
    logic [63:0] cache_key     [NENT];
    logic [63:0] cache_id      [NENT];
    logic [31:0] cache_ver     [NENT];
    logic [31:0] cache_exp     [NENT];
    logic [2:0]  cache_cnt     [NENT];
    logic [3:0]  slot_written  [NENT];
    logic [63:0] cache_loc     [NENT*NLOC];
    logic [31:0] now_tick;
    logic [31:0] ttl_value;
    int          fill_way;
    bit          fill_open;
    bit          fill_drop;

    // Stimulus with its predicted results, and the results still owed by the block.
    job_t               item_queue[$];
    clc_pkg::out_item_t owed_results[$];
    bit                 next_pause;
    bit                 next_wr;
    logic [31:0]        next_val;
    bit                 gen_done;

    logic [63:0] clash_keys[6];
    logic [63:0] pool_keys[8];

    drv_state_t         drv;
    int                 quiet;
    int                 sent_items;
    int                 got_results;
    int                 fail_count;
    int                 k_drv;
    bit                 cfg_done;
    clc_pkg::out_item_t want;

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Reset is held low from the start and released once.
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #(24_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic int set_base(logic [63:0] key);
        logic [63:0] p;
        p = key * clc_pkg::HASH_MULT;
        return int'(p[63:56]) * NWAYS;
    endfunction

    // An entry has expired once now lies past its expiry by one tick up to half the
    // range of the wrapping counter, that half-range distance included.
    function automatic bit has_expired(int e);
        logic [31:0] d;
        logic [31:0] dm;
        d  = now_tick - cache_exp[e];
        dm = d - 32'd1;
        return (d != 32'd0) && !dm[31];
    endfunction

    // Works out the results of one item, updating the predicted cache, and queues it.
    // A lookup that would stream a slot no store ever wrote has its limit trimmed.
    task automatic add_item(input clc_pkg::in_item_t d);
        job_t        j;
        logic [63:0] key;
        int          base, pick, e, w, cnt, pre;
        key  = {d.inode, d.blk_index};
        base = set_base(key);
        j    = '0;
        case (d.mode)
            clc_pkg::MODE_STORE: begin
                if (!fill_open) begin
                    pick = -1;
                    for (w = 0; w < NWAYS; w++)
                        if (pick < 0 && cache_valid[base+w] && cache_key[base+w] == key)
                            pick = base + w;
                    for (w = 0; w < NWAYS; w++)
                        if (pick < 0 && !cache_valid[base+w]) pick = base + w;
                    for (w = 0; w < NWAYS; w++)
                        if (pick < 0 && has_expired(base + w)) pick = base + w;
                    fill_open = 1'b1;
                    if (pick < 0) begin
                        fill_drop = 1'b1;
                    end else begin
                        fill_drop        = 1'b0;
                        fill_way         = pick;
                        cache_valid[pick] = 1'b0;
                        cache_key[pick]   = key;
                        cache_id[pick]    = d.blk_id;
                        cache_ver[pick]   = d.blk_version;
                    end
                end
                if (!fill_drop) begin
                    cache_loc[fill_way*NLOC + d.loc_index] = d.loc_value;
                    slot_written[fill_way][d.loc_index] = 1'b1;
                    if (d.loc_last) begin
                        cache_cnt[fill_way]   = 3'(d.loc_index) + 3'd1;
                        cache_exp[fill_way]   = now_tick + ttl_value;
                        cache_valid[fill_way] = 1'b1;
                    end
                end
                if (d.loc_last) begin
                    fill_open = 1'b0;
                    fill_drop = 1'b0;
                end
            end
            clc_pkg::MODE_LOOKUP: begin
                e = -1;
                for (w = 0; w < NWAYS; w++)
                    if (e < 0 && cache_valid[base+w] && cache_key[base+w] == key) e = base + w;
                if (e >= 0 && d.max_locs != 0 && !has_expired(e)) begin
                    cnt = (cache_cnt[e] < d.max_locs) ? cache_cnt[e] : d.max_locs;
                    pre = 0;
                    while (pre < NLOC && slot_written[e][pre]) pre++;
                    if (pre < cnt) d.max_locs = 3'(pre);
                end
                j.nres = 3'd1;
                j.res[0].last = 1'b1;
                if (e >= 0 && d.max_locs != 0) begin
                    if (has_expired(e)) begin
                        cache_valid[e] = 1'b0;
                    end else begin
                        cnt = (cache_cnt[e] < d.max_locs) ? cache_cnt[e] : d.max_locs;
                        j.nres = 3'(cnt);
                        for (w = 0; w < cnt; w++) begin
                            j.res[w].hit               = 1'b1;
                            j.res[w].chunk_id_out      = cache_id[e];
                            j.res[w].chunk_version_out = cache_ver[e];
                            j.res[w].loc_value_out     = cache_loc[e*NLOC + w];
                            j.res[w].loc_index_out     = 2'(w);
                            j.res[w].last              = (w == cnt - 1);
                        end
                    end
                end
            end
            clc_pkg::MODE_PURGE: begin
                for (e = 0; e < NENT; e++)
                    if (cache_valid[e] && cache_key[e][63:32] == d.inode) cache_valid[e] = 1'b0;
                if (fill_open && !fill_drop && cache_key[fill_way][63:32] == d.inode)
                    fill_drop = 1'b1;
            end
            default: begin
                now_tick = now_tick + 32'd1;
            end
        endcase
        j.d     = d;
        j.pause = next_pause;
        j.wr    = next_wr;
        j.val   = next_val;
        next_pause = 1'b0;
        next_wr    = 1'b0;
        item_queue.push_back(j);
    endtask

    function automatic clc_pkg::in_item_t mk_item(clc_pkg::mode_t m, logic [63:0] key);
        clc_pkg::in_item_t d;
        d.mode          = m;
        d.inode         = key[63:32];
        d.blk_index     = key[31:0];
        d.blk_id        = {$urandom, $urandom};
        d.blk_version   = $urandom;
        d.loc_index     = 2'($urandom_range(3));
        d.loc_value     = {$urandom, $urandom};
        d.loc_last      = 1'($urandom_range(1));
        d.max_locs      = 3'($urandom_range(4));
        return d;
    endfunction

    // A well-formed store: slots below the top one in shuffled order, then the top one
    // with the closing mark, so that every slot the entry will claim is written.
    task automatic gen_store(input logic [63:0] key, input int n);
        clc_pkg::in_item_t d;
        int                order[3];
        int                i, r, t;
        for (i = 0; i < n - 1; i++) order[i] = i;
        for (i = n - 2; i > 0; i--) begin
            r = $urandom_range(i);
            t = order[i];
            order[i] = order[r];
            order[r] = t;
        end
        for (i = 0; i < n - 1; i++) begin
            d = mk_item(clc_pkg::MODE_STORE, key);
            d.loc_index = 2'(order[i]);
            d.loc_last  = 1'b0;
            add_item(d);
        end
        d = mk_item(clc_pkg::MODE_STORE, key);
        d.loc_index = 2'(n - 1);
        d.loc_last  = 1'b1;
        add_item(d);
    endtask

    task automatic gen_lookup(input logic [63:0] key, input int wanted);
        clc_pkg::in_item_t d;
        d = mk_item(clc_pkg::MODE_LOOKUP, key);
        d.max_locs = 3'(wanted);
        add_item(d);
    endtask

    // The register change takes effect for every item queued after this call.
    task automatic set_ttl(input logic [31:0] v);
        next_pause = 1'b1;
        next_wr    = 1'b1;
        next_val   = v;
        ttl_value  = v;
    endtask

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 55) return clash_keys[$urandom_range(5)];
        if (r < 85) return pool_keys[$urandom_range(7)];
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed stores and lookups on a few colliding keys, with ticks to age
    // entries, the odd purge, and stray store items that leave stores open or broken.
    task automatic gen_random(input int count);
        int target, r;
        target = item_queue.size() + count;
        while (item_queue.size() < target) begin
            r = $urandom_range(99);
            if (r < 35) gen_store(pick_key(), $urandom_range(1, 4));
            else if (r < 65) add_item(mk_item(clc_pkg::MODE_LOOKUP, pick_key()));
            else if (r < 82) repeat ($urandom_range(1, 4))
                add_item(mk_item(clc_pkg::MODE_TICK, {$urandom, $urandom}));
            else if (r < 85) add_item(mk_item(clc_pkg::MODE_PURGE, pick_key()));
            else add_item(mk_item(clc_pkg::MODE_STORE, pick_key()));
        end
    endtask

    initial begin
        int                i, found;
        logic [63:0]       key;
        clc_pkg::in_item_t d;

        for (i = 0; i < NENT; i++) begin
            cache_valid[i]  = 1'b0;
            slot_written[i] = '0;
        end
        now_tick   = '0;
        ttl_value  = clc_pkg::TTL_RESET;
        fill_way   = 0;
        fill_open  = 1'b0;
        fill_drop  = 1'b0;
        next_pause = 1'b0;
        next_wr    = 1'b0;
        next_val   = '0;
        gen_done   = 1'b0;

        // Six keys that all land in set zero, so that a set can overflow.
        found = 0;
        for (i = 0; found < 6; i++) begin
            key = {32'd7 + 32'(i & 1), 32'(i)};
            if (set_base(key) == 0) begin
                clash_keys[found] = key;
                found++;
            end
        end
        for (i = 0; i < 8; i++) pool_keys[i] = {$urandom, $urandom};

        // Directed part, with a short TTL so that expiry comes within a few ticks.
        set_ttl(32'd5);
        gen_store(clash_keys[0], 4);
        gen_lookup(clash_keys[0], 4);
        gen_lookup(clash_keys[0], 2);
        gen_lookup(clash_keys[0], 0);
        gen_lookup(pool_keys[0], 4);
        repeat (6) add_item(mk_item(clc_pkg::MODE_TICK, '0));
        // The entry has now expired: the first lookup drops it, the second finds nothing.
        gen_lookup(clash_keys[0], 4);
        gen_lookup(clash_keys[0], 3);
        // Fill every way of the set, then a fifth key has nowhere to go.
        for (i = 1; i < 5; i++) gen_store(clash_keys[i], 1);
        gen_store(clash_keys[5], 2);
        gen_lookup(clash_keys[5], 4);
        gen_lookup(clash_keys[1], 4);
        // A purge of the inode that a store is still filling cancels that store.
        d = mk_item(clc_pkg::MODE_STORE, pool_keys[1]);
        d.loc_index = 2'd0;
        d.loc_last  = 1'b0;
        add_item(d);
        add_item(mk_item(clc_pkg::MODE_PURGE, pool_keys[1]));
        d = mk_item(clc_pkg::MODE_STORE, pool_keys[1]);
        d.loc_index = 2'd1;
        d.loc_last  = 1'b1;
        add_item(d);
        gen_lookup(pool_keys[1], 4);
        // A lookup of the key being filled misses.
        d = mk_item(clc_pkg::MODE_STORE, pool_keys[2]);
        d.loc_index = 2'd0;
        d.loc_last  = 1'b0;
        add_item(d);
        gen_lookup(pool_keys[2], 4);
        d = mk_item(clc_pkg::MODE_STORE, pool_keys[2]);
        d.loc_index = 2'd1;
        d.loc_last  = 1'b1;
        add_item(d);

        set_ttl(32'd40);
        gen_random(110);
        next_pause = 1'b1;
        gen_random(60);
        set_ttl(32'd0);
        gen_random(60);
        set_ttl(32'hFFFF_FFFF);
        gen_random(40);
        set_ttl(32'd12);
        gen_random(100);
        gen_done = 1'b1;

        @(posedge aclk);
        while (item_queue.size() != 0 || owed_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (fail_count < 40)
            $display("mismatch on %s at result %0d: got %h, wanted %h",
                     what, got_results, got, exp_val);
        fail_count++;
    endtask

    // Sender. Before an item marked for a pause it waits until every owed result has
    // arrived and the block has had time to finish any silent work, then performs the
    // APB write if one is due.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            drv     <= DRV_RUN;
            quiet   <= 0;
        end else begin
            case (drv)
                DRV_RUN: begin
                    if (s_valid && s_ready) begin
                        for (k_drv = 0; k_drv < item_queue[0].nres; k_drv++)
                            owed_results.push_back(item_queue[0].res[k_drv]);
                        void'(item_queue.pop_front());
                        sent_items++;
                        cfg_done = 1'b0;
                    end
                    if (!(s_valid && !s_ready)) begin
                        if (item_queue.size() == 0) begin
                            s_valid <= 1'b0;
                        end else if (item_queue[0].pause && !cfg_done) begin
                            s_valid <= 1'b0;
                            quiet   <= 0;
                            drv     <= DRV_DRAIN;
                        end else if (!(sent_items >= 150 && sent_items < 260) &&
                                     $urandom_range(99) < 15) begin
                            s_valid <= 1'b0;
                        end else begin
                            s_valid <= 1'b1;
                            s_data  <= item_queue[0].d;
                        end
                    end
                end
                DRV_DRAIN: begin
                    if (owed_results.size() != 0) begin
                        quiet <= 0;
                    end else if (quiet < DRAIN_CYCLES) begin
                        quiet <= quiet + 1;
                    end else if (item_queue[0].wr) begin
                        psel   <= 1'b1;
                        pwrite <= 1'b1;
                        paddr  <= 3'(clc_pkg::REG_TTL) << 2;
                        pwdata <= item_queue[0].val;
                        drv    <= DRV_SETUP;
                    end else begin
                        cfg_done = 1'b1;
                        drv <= DRV_RUN;
                    end
                end
                DRV_SETUP: begin
                    penable <= 1'b1;
                    drv     <= DRV_ACCESS;
                end
                default: begin
                    if (pready) begin
                        psel    <= 1'b0;
                        penable <= 1'b0;
                        pwrite  <= 1'b0;
                        cfg_done = 1'b1;
                        drv     <= DRV_RUN;
                    end
                end
            endcase
        end
    end

    // Receiver. Each result transfer is checked against the oldest owed result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(m_data.loc_value_out), '0);
                end else begin
                    want = owed_results.pop_front();
                    if (m_data.hit !== want.hit)
                        report_mismatch("hit", 64'(m_data.hit), 64'(want.hit));
                    if (m_data.chunk_id_out !== want.chunk_id_out)
                        report_mismatch("chunk_id_out", m_data.chunk_id_out,
                                        want.chunk_id_out);
                    if (m_data.chunk_version_out !== want.chunk_version_out)
                        report_mismatch("chunk_version_out", 64'(m_data.chunk_version_out),
                                        64'(want.chunk_version_out));
                    if (m_data.loc_value_out !== want.loc_value_out)
                        report_mismatch("loc_value_out", m_data.loc_value_out,
                                        want.loc_value_out);
                    if (m_data.loc_index_out !== want.loc_index_out)
                        report_mismatch("loc_index_out", 64'(m_data.loc_index_out),
                                        64'(want.loc_index_out));
                    if (m_data.last !== want.last)
                        report_mismatch("last", 64'(m_data.last), 64'(want.last));
                end
                got_results++;
            end
            m_ready <= (got_results >= 80 && got_results < 180) || ($urandom_range(99) >= 15);
        end
    end

endmodule
